/* src/sse_vlb_pkg.sv */
`default_nettype none
// ============================================================================
// sse_vlb_pkg
// Shared types and constants of the SSE linked vertex list builder.
// ============================================================================
package sse_vlb_pkg;

    localparam int MAX_SITES = 64;
    localparam int MAX_OPS   = 1024;

    localparam int SITE_W  = 6;
    localparam int POS_W   = 10;
    localparam int CODE_W  = 8;
    localparam int VTX_W   = 13;
    localparam int NSITE_W = 7;
    localparam int PLEN_W  = 11;

    // Configuration register indexes
    localparam logic CFG_NUM_SITES   = 1'b0;
    localparam logic CFG_LIST_LENGTH = 1'b1;

    // Reset values of the configuration registers
    localparam logic [NSITE_W-1:0] NSITES_RESET = NSITE_W'(8);
    localparam logic [PLEN_W-1:0]  PLEN_RESET   = PLEN_W'(512);

    // Input commands
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OP    = 2'd1,
        CMD_CLOSE = 2'd2
    } t_cmd;

    // Single-step operations handed to the table stage
    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_CLEAR,
        UOP_ATTACH,
        UOP_CLOSE_FIRST,
        UOP_CLOSE_END
    } t_uop_kind;

    typedef struct packed {
        t_uop_kind          kind;
        logic [SITE_W-1:0]  site;
        logic [SITE_W-1:0]  other;      // partner site of a bond
        logic               has_other;  // a second attach follows
        logic [VTX_W-1:0]   vtx;        // new leg, or end boundary vertex
        logic [VTX_W-1:0]   nxt;        // new open vertex of the site
    } t_uop;

    // Quotient by 3 of an 8-bit code: multiply by reciprocal 171/512
    function automatic logic [6:0] div3(input logic [CODE_W-1:0] code);
        logic [15:0] prod;
        prod = 16'(code) * 16'd171;
        return prod[15:9];
    endfunction

endpackage
`default_nettype wire

/* src/sse_vertex_link_builder.sv */
`default_nettype none
// ============================================================================
// sse_vertex_link_builder
// Linked vertex list builder for an SSE operator string on a ring of sites.
// ============================================================================
// Items enter as clear, operator or close commands; each produces zero, one
// or two link pairs on the result channel, the final pair of an item flagged
// by o_last. Internally every item is split into one or two table steps,
// issued one per cycle from the input register while no output stall holds
// them: an operator on one site, a clear, and any ignored item take one
// step; a bond operator and a close take two steps, since each step reads
// the site tables at one address and puts at most one pair into the single
// result register. A step passes from the input register through the step
// register r_u to the result register, which drives the outputs.
// The first and last vertex
// tables are 64-entry memories with registered, write-forwarded reads; an
// open bit per site in flops (cleared at reset and by a clear command) says
// whether the site holds operators, so no clearing pass is needed. Number of
// sites and list length are clamped to 2..64 and 1..1024 when written; write
// them only while the block is idle.
// ============================================================================
module sse_vertex_link_builder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item input
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [9:0]  i_position,
    input  wire logic [7:0]  i_op_code,
    input  wire logic [5:0]  i_site_index,
    // link pair output
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [12:0]      o_link_a,
    output logic [12:0]      o_link_b,
    output logic             o_last,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);

    localparam int SW = sse_vlb_pkg::SITE_W;
    localparam int VW = sse_vlb_pkg::VTX_W;
    localparam int NW = sse_vlb_pkg::NSITE_W;
    localparam int PW = sse_vlb_pkg::PLEN_W;

    // ------------------------------------------------------------------
    // Configuration (stored already clamped)
    // ------------------------------------------------------------------
    logic [NW-1:0] r_nsites;
    logic [PW-1:0] r_plen;
    logic [NW-1:0] n_nsites_clamp;
    logic [PW-1:0] n_plen_clamp;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data[NW-1:0] < NW'(2)) begin
            n_nsites_clamp = NW'(2);
        end else if (i_cfg_data[NW-1:0] > NW'(sse_vlb_pkg::MAX_SITES)) begin
            n_nsites_clamp = NW'(sse_vlb_pkg::MAX_SITES);
        end else begin
            n_nsites_clamp = i_cfg_data[NW-1:0];
        end
        if (i_cfg_data == '0) begin
            n_plen_clamp = PW'(1);
        end else if (i_cfg_data > PW'(sse_vlb_pkg::MAX_OPS)) begin
            n_plen_clamp = PW'(sse_vlb_pkg::MAX_OPS);
        end else begin
            n_plen_clamp = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nsites <= sse_vlb_pkg::NSITES_RESET;
            r_plen   <= sse_vlb_pkg::PLEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sse_vlb_pkg::CFG_NUM_SITES:   r_nsites <= n_nsites_clamp;
                sse_vlb_pkg::CFG_LIST_LENGTH: r_plen   <= n_plen_clamp;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves when the result register frees
    // ------------------------------------------------------------------
    logic adv;
    logic r_o_valid;

    assign adv = !r_o_valid || !i_stall;

    // ------------------------------------------------------------------
    // Input register and step issue
    // ------------------------------------------------------------------
    logic                 r_in_valid;
    logic                 r_phase;     // second step of a two-step item
    sse_vlb_pkg::t_cmd    r_cmd;
    logic [9:0]           r_pos;
    logic [7:0]           r_code;
    logic [SW-1:0]        r_site;

    logic [6:0]    quo;
    logic [8:0]    quo3;
    logic          is_bond;
    logic [6:0]    s1;
    logic [6:0]    s2;
    logic          pos_ok;
    logic          op_ok;
    logic          close_ok;
    logic [VW-1:0] v0;
    logic [VW-1:0] endv;
    logic          two_step;
    logic          in_done;
    sse_vlb_pkg::t_uop uop;

    always_comb begin
        quo      = sse_vlb_pkg::div3(r_code);
        quo3     = 9'(quo) * 9'd3;
        is_bond  = ({1'b0, r_code} == quo3);
        s1       = quo - 7'd1;
        s2       = (s1 == '0) ? (r_nsites - 7'd1) : (s1 - 7'd1);
        pos_ok   = ({1'b0, r_pos} < r_plen);
        if (is_bond) begin
            op_ok = pos_ok && (quo != '0) && (s1 < r_nsites);
        end else begin
            op_ok = pos_ok && (quo < r_nsites);
        end
        close_ok = ({1'b0, r_site} < r_nsites);
        v0       = VW'({r_pos, 2'b00}) + VW'(r_nsites);
        endv     = VW'({r_plen, 2'b00}) + VW'(r_nsites) + VW'(r_site);

        uop           = '0;
        uop.kind      = sse_vlb_pkg::UOP_NOP;
        two_step      = 1'b0;
        unique case (r_cmd)
            sse_vlb_pkg::CMD_CLEAR: begin
                uop.kind = sse_vlb_pkg::UOP_CLEAR;
            end
            sse_vlb_pkg::CMD_OP: begin
                if (op_ok && is_bond) begin
                    two_step = 1'b1;
                    uop.kind = sse_vlb_pkg::UOP_ATTACH;
                    if (!r_phase) begin
                        uop.site      = s1[SW-1:0];
                        uop.other     = s2[SW-1:0];
                        uop.has_other = 1'b1;
                        uop.vtx       = v0;
                        uop.nxt       = v0 + VW'(2);
                    end else begin
                        uop.site      = s2[SW-1:0];
                        uop.vtx       = v0 + VW'(1);
                        uop.nxt       = v0 + VW'(3);
                    end
                end else if (op_ok) begin
                    uop.kind = sse_vlb_pkg::UOP_ATTACH;
                    uop.site = quo[SW-1:0];
                    uop.vtx  = v0;
                    uop.nxt  = v0 + VW'(1);
                end
            end
            sse_vlb_pkg::CMD_CLOSE: begin
                if (close_ok) begin
                    two_step = 1'b1;
                    uop.site = r_site;
                    uop.vtx  = endv;
                    uop.kind = r_phase ? sse_vlb_pkg::UOP_CLOSE_END
                                       : sse_vlb_pkg::UOP_CLOSE_FIRST;
                end
            end
            default: ;  // reserved command: ignored
        endcase
    end

    assign in_done = r_in_valid && adv && (!two_step || r_phase);
    assign o_stall = r_in_valid && !in_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
            r_phase    <= 1'b0;
        end else if (in_done) begin
            r_in_valid <= 1'b0;
            r_phase    <= 1'b0;
        end else if (r_in_valid && adv) begin
            r_phase    <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd  <= sse_vlb_pkg::t_cmd'(i_command);
            r_pos  <= i_position;
            r_code <= i_op_code;
            r_site <= i_site_index;
        end
    end

    // ------------------------------------------------------------------
    // Table stage: site tables, open bits, pair selection
    // ------------------------------------------------------------------
    logic                  r_u_valid;
    sse_vlb_pkg::t_uop     r_u;
    logic [VW-1:0]         r_first_mem [sse_vlb_pkg::MAX_SITES];
    logic [VW-1:0]         r_last_mem  [sse_vlb_pkg::MAX_SITES];
    logic [VW-1:0]         r_first_rd;
    logic [VW-1:0]         r_last_rd;
    logic [sse_vlb_pkg::MAX_SITES-1:0] r_open;

    logic          site_open;
    logic          other_open;
    logic          wr_last;
    logic          wr_first;
    logic          emit;
    logic [VW-1:0] pair_a;
    logic [VW-1:0] pair_b;
    logic          pair_last;

    always_comb begin
        site_open  = r_open[r_u.site];
        other_open = r_open[r_u.other];
        wr_last    = adv && r_u_valid && (r_u.kind == sse_vlb_pkg::UOP_ATTACH);
        wr_first   = wr_last && !site_open;
        emit       = 1'b0;
        pair_a     = r_last_rd;
        pair_b     = r_u.vtx;
        pair_last  = 1'b1;
        unique case (r_u.kind)
            sse_vlb_pkg::UOP_ATTACH: begin
                emit      = site_open;
                pair_last = !(r_u.has_other && other_open);
            end
            sse_vlb_pkg::UOP_CLOSE_FIRST: begin
                emit      = site_open;
                pair_a    = VW'(r_u.site);
                pair_b    = r_first_rd;
                pair_last = 1'b0;
            end
            sse_vlb_pkg::UOP_CLOSE_END: begin
                emit   = 1'b1;
                pair_a = site_open ? r_last_rd : VW'(r_u.site);
            end
            sse_vlb_pkg::UOP_NOP, sse_vlb_pkg::UOP_CLEAR: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_valid <= 1'b0;
        end else if (adv) begin
            r_u_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u <= uop;
        end
    end

    // Last vertex table, read forwarded from a write at the same edge
    always_ff @(posedge i_clk) begin
        if (wr_last) begin
            r_last_mem[r_u.site] <= r_u.nxt;
        end
        if (adv) begin
            if (wr_last && (r_u.site == uop.site)) begin
                r_last_rd <= r_u.nxt;
            end else begin
                r_last_rd <= r_last_mem[uop.site];
            end
        end
    end

    // First vertex table
    always_ff @(posedge i_clk) begin
        if (wr_first) begin
            r_first_mem[r_u.site] <= r_u.vtx;
        end
        if (adv) begin
            if (wr_first && (r_u.site == uop.site)) begin
                r_first_rd <= r_u.vtx;
            end else begin
                r_first_rd <= r_first_mem[uop.site];
            end
        end
    end

    // Open bit per site: set by the first attach, dropped by a clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (adv && r_u_valid) begin
            if (r_u.kind == sse_vlb_pkg::UOP_CLEAR) begin
                r_open <= '0;
            end else if (r_u.kind == sse_vlb_pkg::UOP_ATTACH) begin
                r_open[r_u.site] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [VW-1:0] r_link_a;
    logic [VW-1:0] r_link_b;
    logic          r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_u_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_link_a <= pair_a;
            r_link_b <= pair_b;
            r_last   <= pair_last;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_link_a = r_link_a;
    assign o_link_b = r_link_b;
    assign o_last   = r_last;

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the SSE linked vertex list builder.
// ============================================================================
// A tracker class keeps its own copy of the site tables and the two
// configuration registers. It turns every accepted item into the link
// pairs the block must emit, and checks each pair taken from the result
// channel against the oldest one still owed. A short directed part hits
// the table corner cases. Random phases follow, each with new ring and
// string sizes: clear, a run of operators on sites of the ring, then
// closes, with some noise items mixed in. Both channels idle at random.
// Two long receiver hold-offs fill the block so that it stalls its input.
// ============================================================================
module testbench;

    localparam int MAX_SITES = sse_vlb_pkg::MAX_SITES;
    localparam int MAX_OPS   = sse_vlb_pkg::MAX_OPS;
    localparam int SITE_W    = sse_vlb_pkg::SITE_W;
    localparam int POS_W     = sse_vlb_pkg::POS_W;
    localparam int CODE_W    = sse_vlb_pkg::CODE_W;
    localparam int VTX_W     = sse_vlb_pkg::VTX_W;
    localparam int NSITE_W   = sse_vlb_pkg::NSITE_W;
    localparam int PLEN_W    = sse_vlb_pkg::PLEN_W;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    localparam int ITEM_TARGET  = 2000;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 10;    // block latency plus margin
    localparam int WATCHDOG     = 4000;  // cycles with no handshake at all

    // command 3 is not decoded by the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic             last;
    } t_link_pair;

    // ------------------------------------------------------------------------
    // Link tracker: predicted site tables plus the queue of owed pairs
    // ------------------------------------------------------------------------
    class link_list_tracker;
        logic [NSITE_W-1:0] num_sites;
        logic [PLEN_W-1:0]  list_length;
        logic [VTX_W-1:0]   first_vtx[MAX_SITES];
        logic [VTX_W-1:0]   last_vtx[MAX_SITES];
        bit                 first_ok[MAX_SITES];
        bit                 last_ok[MAX_SITES];
        t_link_pair         owed_links[$];
        int                 items;
        int                 pairs;
        int                 writes;
        int                 errors;

        function new();
            num_sites   = sse_vlb_pkg::NSITES_RESET;
            list_length = sse_vlb_pkg::PLEN_RESET;
            items  = 0;
            pairs  = 0;
            writes = 0;
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            for (int k = 0; k < MAX_SITES; k++) begin
                first_vtx[k] = '1;
                last_vtx[k]  = '1;
                first_ok[k]  = 1'b0;
                last_ok[k]   = 1'b0;
            end
        endfunction

        function int sites_now();
            if (num_sites < 2) return 2;
            if (num_sites > MAX_SITES) return MAX_SITES;
            return int'(num_sites);
        endfunction

        function int len_now();
            if (list_length < 1) return 1;
            if (list_length > MAX_OPS) return MAX_OPS;
            return int'(list_length);
        endfunction

        function int pending();
            return owed_links.size();
        endfunction

        function void write_reg(logic idx, logic [PLEN_W-1:0] data);
            writes++;
            if (idx == sse_vlb_pkg::CFG_NUM_SITES) num_sites = data[NSITE_W-1:0];
            else list_length = data;
        endfunction

        function void owe(int a, int b);
            t_link_pair pr;
            pr.a    = VTX_W'(a);
            pr.b    = VTX_W'(b);
            pr.last = 1'b0;
            owed_links.push_back(pr);
        endfunction

        // new leg v on site s: link it to the open vertex, or open the site
        function void join_leg(int s, int v, int nxt);
            if (last_ok[s]) owe(int'(last_vtx[s]), v);
            else begin
                first_vtx[s] = VTX_W'(v);
                first_ok[s]  = 1'b1;
            end
            last_vtx[s] = VTX_W'(nxt);
            last_ok[s]  = 1'b1;
        endfunction

        function void take_item(logic [1:0] cmd, logic [POS_W-1:0] pos,
                                logic [CODE_W-1:0] code, logic [SITE_W-1:0] site);
            int n_s;
            int p_len;
            int v0;
            int quo;
            int s1;
            int s2;
            int endv;
            int owed_at_start;
            n_s    = sites_now();
            p_len  = len_now();
            owed_at_start = owed_links.size();
            items++;
            if (cmd == sse_vlb_pkg::CMD_CLEAR) begin
                wipe();
            end else if (cmd == sse_vlb_pkg::CMD_OP) begin
                v0  = 4 * int'(pos) + n_s;
                quo = int'(code) / 3;
                if (int'(pos) < p_len) begin
                    if (int'(code) % 3 == 0) begin
                        // bond; code zero and sites off the ring drop out
                        if (code != 0 && quo - 1 < n_s) begin
                            s1 = quo - 1;
                            s2 = (s1 + n_s - 1) % n_s;
                            join_leg(s1, v0, v0 + 2);
                            join_leg(s2, v0 + 1, v0 + 3);
                        end
                    end else if (quo < n_s) begin
                        join_leg(quo, v0, v0 + 1);
                    end
                end
            end else if (cmd == sse_vlb_pkg::CMD_CLOSE && int'(site) < n_s) begin
                endv = 4 * p_len + n_s + int'(site);
                if (first_ok[site]) owe(int'(site), int'(first_vtx[site]));
                if (last_ok[site]) owe(int'(last_vtx[site]), endv);
                if (!first_ok[site] && !last_ok[site]) owe(int'(site), endv);
            end
            if (owed_links.size() > owed_at_start)
                owed_links[owed_links.size() - 1].last = 1'b1;
        endfunction

        function void check_pair(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b, logic last);
            t_link_pair want;
            if (owed_links.size() == 0) begin
                $error("link pair with nothing owed: a=%0d b=%0d last=%0d", a, b, last);
                errors++;
                return;
            end
            want = owed_links.pop_front();
            pairs++;
            if (a !== want.a) begin
                $error("link_a expected %0d actual %0d", want.a, a);
                errors++;
            end
            if (b !== want.b) begin
                $error("link_b expected %0d actual %0d", want.b, b);
                errors++;
            end
            if (last !== want.last) begin
                $error("last expected %0d actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic [1:0]         i_command    = '0;
    logic [POS_W-1:0]   i_position   = '0;
    logic [CODE_W-1:0]  i_op_code    = '0;
    logic [SITE_W-1:0]  i_site_index = '0;
    logic               i_stall      = 1'b0;
    logic               i_cfg_valid  = 1'b0;
    logic               i_cfg_index  = 1'b0;
    logic [PLEN_W-1:0]  i_cfg_data   = '0;

    logic               o_stall;
    logic               o_valid;
    logic [VTX_W-1:0]   o_link_a;
    logic [VTX_W-1:0]   o_link_b;
    logic               o_last;
    logic               o_cfg_ready;

    link_list_tracker   board;

    // idle rates in percent, changed per phase by the stimulus
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // hold-off requests: the stimulus bumps the count, the receiver serves it
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    sse_vertex_link_builder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_op_code    (i_op_code),
        .i_site_index (i_site_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_link_a     (o_link_a),
        .o_link_b     (o_link_b),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result side: check every accepted pair, then pick the next stall.
    // A pending hold-off request keeps stall high until its hold-off count runs out.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_pair(o_link_a, o_link_b, o_last);
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake on any channel restarts the count
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG);
            $display("sse_vertex_link_builder test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Valid stays high from one item to the next unless a gap is
    // drawn, so it is never lowered and raised within one step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] cmd, input int pos, input int code,
                             input int site);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_position   <= POS_W'(pos);
        i_op_code    <= CODE_W'(code);
        i_site_index <= SITE_W'(site);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.take_item(cmd, POS_W'(pos), CODE_W'(code), SITE_W'(site));
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(3)), $urandom_range(1023), $urandom_range(255),
                  $urandom_range(63));
    endtask

    // hold input and wait out every owed pair, then the pipeline tail,
    // since ignored items and clears leave no pair behind
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= PLEN_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, PLEN_W'(data));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(input int n_data, input int p_data);
        wait_idle();
        write_reg(sse_vlb_pkg::CFG_NUM_SITES, n_data);
        write_reg(sse_vlb_pkg::CFG_LIST_LENGTH, p_data);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int ph;
        int n_data;
        int p_data;
        int eff_n;
        int eff_p;
        int n_ops;
        int s;
        bit late_hold_done;

        board = new();
        late_hold_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct <= 24;
        recv_idle_pct <= 61;

        // --- directed, reset sizes: 8 sites, 512 slots ---
        send_item(sse_vlb_pkg::CMD_CLEAR, 0, 0, 0);
        send_item(sse_vlb_pkg::CMD_CLOSE, 0, 0, 0);        // empty site: one pair to its end
        send_item(sse_vlb_pkg::CMD_OP, 0, 1, 0);           // opens site 0
        send_item(sse_vlb_pkg::CMD_OP, 1, 2, 5);           // links on site 0
        send_item(sse_vlb_pkg::CMD_OP, 2, 3, 0);           // bond 0 and wrap to site 7
        send_item(sse_vlb_pkg::CMD_OP, 511, 24, 0);        // bond 7 and 6, last slot
        send_item(sse_vlb_pkg::CMD_OP, 3, 0, 0);           // code zero, dropped
        send_item(sse_vlb_pkg::CMD_OP, 4, 27, 0);          // bond site off the ring
        send_item(sse_vlb_pkg::CMD_OP, 5, 25, 0);          // single site off the ring
        send_item(sse_vlb_pkg::CMD_OP, 512, 1, 0);         // slot past the string
        send_item(sse_vlb_pkg::CMD_OP, 1023, 255, 63);     // all ones, dropped
        send_item(CMD_UNUSED, 1023, 255, 63);              // undecoded command
        send_item(sse_vlb_pkg::CMD_CLOSE, 0, 0, 8);        // close off the ring
        send_item(sse_vlb_pkg::CMD_CLOSE, 1023, 255, 63);
        send_item(sse_vlb_pkg::CMD_CLOSE, 0, 0, 0);
        send_item(sse_vlb_pkg::CMD_CLOSE, 0, 0, 7);
        send_item(sse_vlb_pkg::CMD_CLOSE, 0, 0, 6);
        send_item(sse_vlb_pkg::CMD_CLOSE, 0, 0, 3);
        send_item(sse_vlb_pkg::CMD_CLEAR, 1023, 255, 63);
        send_item(sse_vlb_pkg::CMD_CLOSE, 0, 0, 0);        // cleared site is empty again

        // --- directed, largest sizes ---
        set_sizes(MAX_SITES, MAX_OPS);
        send_item(sse_vlb_pkg::CMD_OP, 1023, 192, 0);      // bond 63 and 62, top vertices
        send_item(sse_vlb_pkg::CMD_OP, 0, 191, 0);         // single on site 63
        send_item(sse_vlb_pkg::CMD_OP, 1023, 3, 0);        // bond 0 wrapping to 63
        send_item(sse_vlb_pkg::CMD_CLOSE, 0, 0, 63);
        send_item(sse_vlb_pkg::CMD_CLOSE, 0, 0, 0);
        send_item(sse_vlb_pkg::CMD_CLOSE, 0, 0, 62);

        // --- random phases ---
        ph = 0;
        while (board.items < ITEM_TARGET) begin
            if (board.items < ITEM_TARGET / 3) begin
                send_idle_pct <= 24;
                recv_idle_pct <= 61;
            end else if (board.items < 2 * ITEM_TARGET / 3) begin
                send_idle_pct <= 61;
                recv_idle_pct <= 24;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end

            // first phases pin the extremes, including clamped writes
            case (ph)
                0: begin n_data = 2;    p_data = 1;    end
                1: begin n_data = 64;   p_data = 1024; end
                2: begin n_data = 0;    p_data = 0;    end
                3: begin n_data = 2047; p_data = 2047; end
                default: begin
                    n_data = ($urandom_range(7) == 0) ? $urandom_range(2047)
                                                      : $urandom_range(2, 64);
                    p_data = ($urandom_range(7) == 0) ? $urandom_range(2047)
                                                      : $urandom_range(1, 1024);
                end
            endcase
            set_sizes(n_data, p_data);
            eff_n = board.sites_now();
            eff_p = board.len_now();

            // block fills behind a stalled receiver, once early, once later
            if (ph == 4 || (!late_hold_done && recv_idle_pct == 0 && ph > 4)) begin
                hold_reqs <= hold_reqs + 1;
                if (ph > 4) late_hold_done = 1'b1;
            end

            send_item(sse_vlb_pkg::CMD_CLEAR, $urandom_range(1023), $urandom_range(255),
                      $urandom_range(63));

            // operators on ring sites: bond code 3*(s+1), single 3*s+1 or +2
            n_ops = $urandom_range(4, 48);
            repeat (n_ops) begin
                if ($urandom_range(9) == 0) begin
                    send_noise();
                end else begin
                    s = $urandom_range(eff_n - 1);
                    send_item(sse_vlb_pkg::CMD_OP, $urandom_range(eff_p - 1),
                              $urandom_range(1) ? 3 * (s + 1) : 3 * s + 1 + $urandom_range(1),
                              $urandom_range(63));
                end
            end

            // close the whole ring when small, a random handful otherwise
            for (int k = 0; k < ((eff_n <= 16) ? eff_n : 16); k++) begin
                if ($urandom_range(9) == 0) send_noise();
                s = (eff_n <= 16) ? k : $urandom_range(eff_n - 1);
                send_item(sse_vlb_pkg::CMD_CLOSE, $urandom_range(1023), $urandom_range(255),
                          s);
            end
            ph++;
        end

        wait_idle();

        $display("Covered %0d items and %0d link pairs over %0d size settings (%0d writes).",
                 board.items, board.pairs, ph + 2, board.writes);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("sse_vertex_link_builder test passed");
        end else begin
            if (board.pending() != 0)
                $error("%0d link pairs never arrived", board.pending());
            $display("sse_vertex_link_builder test failed");
        end
        $finish;
    end

endmodule
